@@ rtl/core/ggcd_pkg.sv @@
package ggcd_pkg;

	localparam int NODES      = 4096;
	localparam int FLAG_CODES = 16;
	localparam int ADDR_W     = $clog2(NODES);
	localparam int VAL_W      = 32;
	localparam int ID_W       = 13;
	localparam int COEF_W     = 31;
	localparam int MASK_W     = 16;
	localparam int TERM_W     = 36;
	localparam int MAG_W      = 35;
	localparam int IN_DATA_W  = 96;
	localparam int IN_USER_W  = 1;
	localparam int OUT_DATA_W = 64;
	localparam int OUT_USER_W = 2;
	localparam int CFG_IDX_W  = 2;

	localparam logic [ID_W-1:0] FLAG_LIMIT = ID_W'((FLAG_CODES < MASK_W) ? FLAG_CODES : MASK_W);

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_INV_DX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HALF_INV_DY = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FLAG_MASK   = 2'd2;

	localparam logic [COEF_W-1:0] HALF_INV_RESET = COEF_W'(32768);
	localparam logic [MASK_W-1:0] MASK_RESET     = MASK_W'(1);

	typedef logic signed [ID_W-1:0]   id_t;
	typedef logic signed [VAL_W-1:0]  val_t;
	typedef logic signed [TERM_W-1:0] term_t;

	typedef struct packed {
		term_t term;
		logic  err;
	} side_t;

	function automatic term_t ext_val(input val_t v);
		return {{(TERM_W-VAL_W){v[VAL_W-1]}}, v};
	endfunction

	// contribution of one side along an axis
	function automatic side_t side_term(input id_t id, input id_t opp, input val_t v_id,
			input val_t v_opp, input val_t f, input logic [MASK_W-1:0] mask);
		side_t r;
		logic [ID_W-1:0] k;
		term_t f2;
		k = ~id;
		f2 = ext_val(f) <<< 1;
		r.term = '0;
		r.err = 1'b0;
		if (!id[ID_W-1]) begin
			r.term = ext_val(v_id);
		end else if ((k < FLAG_LIMIT) && mask[k[3:0]]) begin
			if (opp[ID_W-1]) begin
				r.err = 1'b1;
				r.term = f2;
			end else begin
				r.term = f2 - ext_val(v_opp);
			end
		end
		return r;
	endfunction

endpackage

@@ rtl/core/grid_gradient_central_difference.sv @@
// Central-difference gradient over a node value store.
// Input channel (s_*): s_tuser selects the operation. A load transaction
// writes node_value into the store at node_index. A compute transaction
// reads the node and its four neighbours from the single-port store, one
// read per cycle, then forms both differences and scales them with one
// shared 32x31 multiplier, two products per axis. A compute transaction
// occupies the block until its result is loaded into the output register,
// where it is presented on m_*. s_tready is high only while the sequencer
// is idle. Loads produce no output transaction.
// Output channel (m_*): one transaction per compute, held in an output
// register. While it waits on m_tready, further loads are still taken and
// the next compute runs until its result is ready; it then waits for the
// output register to drain.
// Configuration: cfg_we writes register cfg_index (0 half_inv_dx,
// 1 half_inv_dy, 2 boundary_flag_mask); write only while idle.
// Reset: arst_n clears the sequencer and output valid and restores the
// register defaults; store contents are undefined until loaded.
module grid_gradient_central_difference (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// node_index[11:0], node_value[43:12], west_id[56:44], east_id[69:57],
	// south_id[82:70], north_id[95:83]
	input  logic [ggcd_pkg::IN_DATA_W-1:0]      s_tdata,
	// op[0]
	input  logic [ggcd_pkg::IN_USER_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// grad_x[31:0], grad_y[63:32]
	output logic [ggcd_pkg::OUT_DATA_W-1:0]     m_tdata,
	// corner_error[0], saturated[1]
	output logic [ggcd_pkg::OUT_USER_W-1:0]     m_tuser,
	input  logic                                cfg_we,
	input  logic [ggcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ggcd_pkg::COEF_W-1:0]         cfg_data
);

	import ggcd_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_F, ST_RD_W, ST_RD_E, ST_RD_S, ST_RD_N, ST_CAP_N,
		ST_DIFF, ST_MUL_L, ST_MUL_H, ST_ACC
	} state_t;

	state_t state_q;

	logic [COEF_W-1:0] half_inv_dx_q, half_inv_dy_q;
	logic [MASK_W-1:0] mask_q;

	logic [ADDR_W-1:0] node_q;
	id_t  west_q, east_q, south_q, north_q;
	val_t f_q, vw_q, ve_q, vs_q, vn_q;

	logic [MAG_W-1:0] mag_x_q, mag_y_q;
	logic             neg_x_q, neg_y_q, err_q, sat_q, axis_q;
	logic [63:0]      prod_q;
	logic [47:0]      acc_q;
	logic [VAL_W-1:0] gx_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [VAL_W-1:0]  ram_rdata;
	logic              s_accept;
	logic              out_load;

	side_t tw_x, te_x, ts_y, tn_y;
	term_t dx, dy;

	logic [MAG_W-1:0]  mag_sel;
	logic              neg_sel;
	logic [COEF_W-1:0] coef_sel;
	logic [31:0]       mul_a;
	logic [63:0]       mul_p;
	logic [51:0]       qsum;
	logic [VAL_W-1:0]  res;
	logic              res_sat;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign out_load = (state_q == ST_ACC) && axis_q && (!m_tvalid || m_tready);

	always_comb begin
		ram_we = 1'b0;
		ram_addr = node_q;
		case (state_q)
			ST_IDLE: begin
				ram_addr = s_tdata[ADDR_W-1:0];
				ram_we = s_accept && (s_tuser[0] == OP_LOAD);
			end
			ST_RD_F: ram_addr = node_q;
			ST_RD_W: ram_addr = west_q[ADDR_W-1:0];
			ST_RD_E: ram_addr = east_q[ADDR_W-1:0];
			ST_RD_S: ram_addr = south_q[ADDR_W-1:0];
			ST_RD_N: ram_addr = north_q[ADDR_W-1:0];
			default: ram_addr = node_q;
		endcase
	end

	ggcd_ram #(
		.WIDTH(VAL_W),
		.DEPTH(NODES)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(s_tdata[43:12]),
		.rdata(ram_rdata)
	);

	always_comb begin
		te_x = side_term(east_q, west_q, ve_q, vw_q, f_q, mask_q);
		tw_x = side_term(west_q, east_q, vw_q, ve_q, f_q, mask_q);
		tn_y = side_term(north_q, south_q, vn_q, vs_q, f_q, mask_q);
		ts_y = side_term(south_q, north_q, vs_q, vn_q, f_q, mask_q);
		dx = te_x.term - tw_x.term;
		dy = tn_y.term - ts_y.term;
	end

	// shared multiplier: low 32 bits of the magnitude, then its top bits
	always_comb begin
		mag_sel = axis_q ? mag_y_q : mag_x_q;
		neg_sel = axis_q ? neg_y_q : neg_x_q;
		coef_sel = axis_q ? half_inv_dy_q : half_inv_dx_q;
		mul_a = (state_q == ST_MUL_H) ? {29'b0, mag_sel[MAG_W-1:32]} : mag_sel[31:0];
		mul_p = {32'b0, mul_a} * {33'b0, coef_sel};
		qsum = {4'b0, acc_q} + {2'b0, prod_q[33:0], 16'b0};
		res_sat = 1'b0;
		if (neg_sel) begin
			if (qsum > 52'h0_0000_8000_0000) begin
				res_sat = 1'b1;
				res = 32'h8000_0000;
			end else begin
				res = 32'h0 - qsum[31:0];
			end
		end else begin
			if (qsum > 52'h0_0000_7FFF_FFFF) begin
				res_sat = 1'b1;
				res = 32'h7FFF_FFFF;
			end else begin
				res = qsum[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			half_inv_dx_q <= HALF_INV_RESET;
			half_inv_dy_q <= HALF_INV_RESET;
			mask_q <= MASK_RESET;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			m_tuser <= '0;
			node_q <= '0;
			west_q <= '0;
			east_q <= '0;
			south_q <= '0;
			north_q <= '0;
			f_q <= '0;
			vw_q <= '0;
			ve_q <= '0;
			vs_q <= '0;
			vn_q <= '0;
			mag_x_q <= '0;
			mag_y_q <= '0;
			neg_x_q <= 1'b0;
			neg_y_q <= 1'b0;
			err_q <= 1'b0;
			sat_q <= 1'b0;
			axis_q <= 1'b0;
			prod_q <= '0;
			acc_q <= '0;
			gx_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HALF_INV_DX: half_inv_dx_q <= cfg_data;
					REG_HALF_INV_DY: half_inv_dy_q <= cfg_data;
					REG_FLAG_MASK:   mask_q <= cfg_data[MASK_W-1:0];
					default: ;
				endcase
			end
			if (out_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_accept && (s_tuser[0] == OP_COMPUTE)) begin
						node_q <= s_tdata[ADDR_W-1:0];
						west_q <= s_tdata[56:44];
						east_q <= s_tdata[69:57];
						south_q <= s_tdata[82:70];
						north_q <= s_tdata[95:83];
						state_q <= ST_RD_F;
					end
				end
				ST_RD_F: state_q <= ST_RD_W;
				ST_RD_W: begin
					f_q <= ram_rdata;
					state_q <= ST_RD_E;
				end
				ST_RD_E: begin
					vw_q <= ram_rdata;
					state_q <= ST_RD_S;
				end
				ST_RD_S: begin
					ve_q <= ram_rdata;
					state_q <= ST_RD_N;
				end
				ST_RD_N: begin
					vs_q <= ram_rdata;
					state_q <= ST_CAP_N;
				end
				ST_CAP_N: begin
					vn_q <= ram_rdata;
					state_q <= ST_DIFF;
				end
				ST_DIFF: begin
					neg_x_q <= dx[TERM_W-1];
					neg_y_q <= dy[TERM_W-1];
					mag_x_q <= dx[TERM_W-1] ? MAG_W'(-dx) : dx[MAG_W-1:0];
					mag_y_q <= dy[TERM_W-1] ? MAG_W'(-dy) : dy[MAG_W-1:0];
					err_q <= te_x.err | tw_x.err | tn_y.err | ts_y.err;
					sat_q <= 1'b0;
					axis_q <= 1'b0;
					state_q <= ST_MUL_L;
				end
				ST_MUL_L: begin
					prod_q <= mul_p;
					state_q <= ST_MUL_H;
				end
				ST_MUL_H: begin
					acc_q <= 48'((prod_q + 64'h8000) >> 16);
					prod_q <= mul_p;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!axis_q) begin
						gx_q <= res;
						sat_q <= sat_q | res_sat;
						axis_q <= 1'b1;
						state_q <= ST_MUL_L;
					end else if (out_load) begin
						m_tdata <= {res, gx_q};
						m_tuser <= {sat_q | res_sat, err_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/ggcd_ram.sv @@
module ggcd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule
